@@ rtl/core/wellrng_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and mixing functions for the multi-stream WELL1024a generator.
package wellrng_pkg;

    // Field widths
    localparam int STREAM_W = 7;
    localparam int IDX_W    = 5;
    localparam int WORD_W   = 32;

    // Ring geometry and stream count default
    localparam int RING_LEN    = 32;
    localparam int THREADS_DEF = 128;
    localparam int QUEUE_DEPTH = 2;

    // Recurrence taps, relative to the ring position
    localparam logic [IDX_W-1:0] OFF_0    = 5'd0;
    localparam logic [IDX_W-1:0] OFF_M1   = 5'd3;
    localparam logic [IDX_W-1:0] OFF_M2   = 5'd24;
    localparam logic [IDX_W-1:0] OFF_M3   = 5'd10;
    localparam logic [IDX_W-1:0] OFF_LAST = 5'd31;

    // Shift amounts of the recurrence
    localparam int SH_M1   = 8;
    localparam int SH_M2   = 19;
    localparam int SH_M3   = 14;
    localparam int SH_LAST = 11;
    localparam int SH_Z1   = 7;
    localparam int SH_Z2   = 13;

    // Ring read sequence: five reads per draw
    typedef logic [2:0] step_t;
    localparam step_t LAST_STEP = 3'd4;

    typedef enum logic {
        OP_DRAW = 1'b0,
        OP_SEED = 1'b1
    } opcode_t;

    typedef struct packed {
        opcode_t             opcode;
        logic [STREAM_W-1:0] stream;
        logic [IDX_W-1:0]    word_index;
        logic [WORD_W-1:0]   seed_word;
    } rng_in_t;

    typedef struct packed {
        logic [WORD_W-1:0]   random_word;
        logic [STREAM_W-1:0] stream_out;
    } rng_out_t;

    // Number of streams the stream field can actually reach
    function automatic int stream_count(input int threads);
        return (threads < (1 << STREAM_W)) ? threads : (1 << STREAM_W);
    endfunction

    function automatic logic [WORD_W-1:0] mix_right(input logic [WORD_W-1:0] v, input int s);
        return v ^ (v >> s);
    endfunction

    function automatic logic [WORD_W-1:0] mix_left(input logic [WORD_W-1:0] v, input int s);
        return v ^ (v << s);
    endfunction

    // Tap read at each step; the position word itself is read last
    function automatic logic [IDX_W-1:0] read_offset(input step_t step);
        logic [IDX_W-1:0] off;
        unique case (step)
            3'd0:    off = OFF_LAST;
            3'd1:    off = OFF_M1;
            3'd2:    off = OFF_M2;
            3'd3:    off = OFF_M3;
            default: off = OFF_0;
        endcase
        return off;
    endfunction

endpackage

@@ rtl/core/wellrng_ram.sv @@
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and one registered read port.
module wellrng_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write, and read the value held before this cycle's write
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ rtl/core/wellrng_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts command beats and drops those that address a missing stream.
module wellrng_front
    import wellrng_pkg::*;
#(
    parameter int THREADS = THREADS_DEF
) (
    input  logic    s_valid,
    output logic    s_ready,
    input  rng_in_t s_data,
    input  logic    init_done,
    input  logic    push_ready,
    output logic    push_valid,
    output rng_in_t push_data
);

    localparam int STREAMS = stream_count(THREADS);

    logic in_range;

    // Hold off input until the store is cleared and the queue has room
    assign s_ready = init_done && push_ready;

    // Drop commands for streams beyond the configured count
    assign in_range   = int'(s_data.stream) < STREAMS;
    assign push_valid = s_valid && s_ready && in_range;
    assign push_data  = s_data;

endmodule

@@ rtl/core/wellrng_queue.sv @@
`timescale 1ns / 1ps
// Short command queue between the front end and the execution unit.
module wellrng_queue
    import wellrng_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  rng_in_t in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output rng_in_t out_data
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    rng_in_t        entry_reg [QUEUE_DEPTH];
    logic [PW-1:0]  wptr_reg, wptr_next;
    logic [PW-1:0]  rptr_reg, rptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           push, pop;

    assign in_ready  = count_reg != CW'(QUEUE_DEPTH);
    assign out_valid = count_reg != '0;
    assign out_data  = entry_reg[rptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Advance pointers and occupancy
    always_comb begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push) begin
            wptr_next = (wptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (pop) begin
            rptr_next = (rptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // Store the incoming beat
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wptr_reg] <= in_data;
        end
    end

endmodule

@@ rtl/core/wellrng_exec.sv @@
`timescale 1ns / 1ps
// Execution unit: ring and position memories, read sequencer, recurrence and result buffer.
module wellrng_exec
    import wellrng_pkg::*;
#(
    parameter int THREADS = THREADS_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     q_valid,
    output logic     q_ready,
    input  rng_in_t  q_data,
    output logic     m_valid,
    input  logic     m_ready,
    output rng_out_t m_data,
    output logic     init_done
);

    localparam int STREAMS    = stream_count(THREADS);
    localparam int SW         = (STREAMS > 1) ? $clog2(STREAMS) : 1;
    localparam int RING_DEPTH = STREAMS * RING_LEN;
    localparam int RAW        = $clog2(RING_DEPTH);
    localparam logic [IDX_W-1:0] POS_BACK = OFF_LAST;

    typedef enum logic {
        RD_IDLE,
        RD_RUN
    } rd_state_t;

    function automatic logic [RAW-1:0] ring_addr(input logic [SW-1:0] s,
                                                 input logic [IDX_W-1:0] w);
        return RAW'({s, w});
    endfunction

    // Memory ports
    logic              ring_we;
    logic [RAW-1:0]    ring_waddr, ring_raddr;
    logic [WORD_W-1:0] ring_wdata, ring_rdata;
    logic              pos_we;
    logic [SW-1:0]     pos_waddr, pos_raddr;
    logic [IDX_W-1:0]  pos_wdata, pos_rdata;

    // Control state
    rd_state_t         rd_state_reg, rd_state_next;
    step_t             step_reg, step_next;
    logic              rd_live_d_reg, rd_live_d_next;
    step_t             rd_step_d_reg, rd_step_d_next;
    logic              w2_reg, w2_next;
    logic              fwd_hit_reg, fwd_hit_next;
    logic [1:0]        res_cnt_reg, res_cnt_next;
    logic [RAW-1:0]    clr_cnt_reg, clr_cnt_next;
    logic              init_done_reg, init_done_next;
    logic              ob_wptr_reg, ob_rptr_reg;
    logic [1:0]        ob_cnt_reg, ob_cnt_next;

    // Payload state
    logic [SW-1:0]     rd_stream_reg, rd_stream_next;
    logic [IDX_W-1:0]  rd_pos_reg, rd_pos_next;
    logic [IDX_W-1:0]  fwd_pos_reg, fwd_pos_next;
    logic [SW-1:0]     wr_stream_reg, wr_stream_next;
    logic [IDX_W-1:0]  wr_pos_reg, wr_pos_next;
    logic [WORD_W-1:0] w_reg [4];
    logic [WORD_W-1:0] nw_reg, nw_next;
    rng_out_t          ob_data_reg [2];

    // Combinational
    logic              rd_last, rd_free, head_is_draw, can_draw, can_seed;
    logic              pop_draw, pop_seed, w1, fwd_rd, fwd_wr, out_take;
    logic [SW-1:0]     head_stream;
    logic [IDX_W-1:0]  pos_cur;
    logic [WORD_W-1:0] z1, z2, nw;

    wellrng_ram #(.WIDTH(WORD_W), .DEPTH(RING_DEPTH)) u_ring_ram (
        .aclk    (aclk),
        .wr_en   (ring_we),
        .wr_addr (ring_waddr),
        .wr_data (ring_wdata),
        .rd_addr (ring_raddr),
        .rd_data (ring_rdata)
    );

    wellrng_ram #(.WIDTH(IDX_W), .DEPTH(STREAMS)) u_pos_ram (
        .aclk    (aclk),
        .wr_en   (pos_we),
        .wr_addr (pos_waddr),
        .wr_data (pos_wdata),
        .rd_addr (pos_raddr),
        .rd_data (pos_rdata)
    );

    // Issue decisions for the queue head
    assign head_stream  = SW'(q_data.stream);
    assign head_is_draw = q_data.opcode == OP_DRAW;
    assign rd_last      = (rd_state_reg == RD_RUN) && (step_reg == LAST_STEP);
    assign rd_free      = (rd_state_reg == RD_IDLE) || rd_last;
    assign w1           = rd_live_d_reg && (rd_step_d_reg == LAST_STEP);
    assign can_draw     = rd_free && (res_cnt_reg != 2'd2);
    assign can_seed     = (rd_state_reg == RD_IDLE) && !w1 && !w2_reg;
    assign q_ready      = init_done_reg && (head_is_draw ? can_draw : can_seed);
    assign pop_draw     = q_valid && q_ready && head_is_draw;
    assign pop_seed     = q_valid && q_ready && !head_is_draw;
    assign init_done    = init_done_reg;

    // Bypass a position update that has not reached the position memory yet
    assign fwd_rd = rd_last && (head_stream == rd_stream_reg);
    assign fwd_wr = w1 && (head_stream == wr_stream_reg);

    // Ring read address for the current step
    assign pos_cur    = (step_reg == '0) ? (fwd_hit_reg ? fwd_pos_reg : pos_rdata) : rd_pos_reg;
    assign ring_raddr = ring_addr(rd_stream_reg, pos_cur + read_offset(step_reg));
    assign pos_raddr  = head_stream;

    // Recurrence: taps 31, 3, 24, 10 captured, position word straight from the RAM
    assign z1 = ring_rdata ^ mix_right(w_reg[1], SH_M1);
    assign z2 = mix_left(w_reg[2], SH_M2) ^ mix_left(w_reg[3], SH_M3);
    assign nw = mix_left(w_reg[0], SH_LAST) ^ mix_left(z1, SH_Z1) ^ mix_left(z2, SH_Z2);

    // Ring write port: clear pass, then the two draw writes or a seed
    always_comb begin
        ring_we    = 1'b0;
        ring_waddr = clr_cnt_reg;
        ring_wdata = '0;
        if (!init_done_reg) begin
            ring_we = 1'b1;
        end else if (w1) begin
            ring_we    = 1'b1;
            ring_waddr = ring_addr(wr_stream_reg, wr_pos_reg);
            ring_wdata = z1 ^ z2;
        end else if (w2_reg) begin
            ring_we    = 1'b1;
            ring_waddr = ring_addr(wr_stream_reg, wr_pos_reg + POS_BACK);
            ring_wdata = nw_reg;
        end else if (pop_seed) begin
            ring_we    = 1'b1;
            ring_waddr = ring_addr(head_stream, q_data.word_index);
            ring_wdata = q_data.seed_word;
        end
    end

    // Position write port
    always_comb begin
        pos_we    = 1'b0;
        pos_waddr = SW'(clr_cnt_reg >> IDX_W);
        pos_wdata = '0;
        if (!init_done_reg) begin
            pos_we = 1'b1;
        end else if (w1) begin
            pos_we    = 1'b1;
            pos_waddr = wr_stream_reg;
            pos_wdata = wr_pos_reg + POS_BACK;
        end else if (pop_seed) begin
            pos_we    = 1'b1;
            pos_waddr = head_stream;
        end
    end

    // Read sequencer and write-back control
    always_comb begin
        rd_state_next  = rd_state_reg;
        step_next      = step_reg;
        rd_stream_next = rd_stream_reg;
        rd_pos_next    = rd_pos_reg;
        fwd_hit_next   = fwd_hit_reg;
        fwd_pos_next   = fwd_pos_reg;
        wr_stream_next = wr_stream_reg;
        wr_pos_next    = wr_pos_reg;
        rd_live_d_next = rd_state_reg == RD_RUN;
        rd_step_d_next = step_reg;
        w2_next        = w1;
        nw_next        = w1 ? nw : nw_reg;

        unique case (rd_state_reg)
            RD_IDLE: begin
                if (pop_draw) begin
                    rd_state_next = RD_RUN;
                    step_next     = '0;
                end
            end
            RD_RUN: begin
                if (step_reg == '0) begin
                    rd_pos_next = pos_cur;
                end
                if (step_reg == LAST_STEP) begin
                    wr_stream_next = rd_stream_reg;
                    wr_pos_next    = rd_pos_reg;
                    step_next      = '0;
                    if (!pop_draw) begin
                        rd_state_next = RD_IDLE;
                    end
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            default: rd_state_next = RD_IDLE;
        endcase

        if (pop_draw) begin
            rd_stream_next = head_stream;
            fwd_hit_next   = fwd_rd || fwd_wr;
            fwd_pos_next   = fwd_rd ? rd_pos_reg + POS_BACK : wr_pos_reg + POS_BACK;
        end
    end

    // Result credits, output buffer and clear pass
    assign out_take = m_valid && m_ready;
    assign m_valid  = ob_cnt_reg != '0;
    assign m_data   = ob_data_reg[ob_rptr_reg];

    always_comb begin
        res_cnt_next = res_cnt_reg;
        if (pop_draw && !out_take) begin
            res_cnt_next = res_cnt_reg + 1'b1;
        end else if (out_take && !pop_draw) begin
            res_cnt_next = res_cnt_reg - 1'b1;
        end

        ob_cnt_next = ob_cnt_reg;
        if (w2_reg && !out_take) begin
            ob_cnt_next = ob_cnt_reg + 1'b1;
        end else if (out_take && !w2_reg) begin
            ob_cnt_next = ob_cnt_reg - 1'b1;
        end

        clr_cnt_next   = clr_cnt_reg;
        init_done_next = init_done_reg;
        if (!init_done_reg) begin
            if (clr_cnt_reg == RAW'(RING_DEPTH - 1)) begin
                init_done_next = 1'b1;
            end else begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_state_reg  <= RD_IDLE;
            step_reg      <= '0;
            rd_live_d_reg <= 1'b0;
            rd_step_d_reg <= '0;
            w2_reg        <= 1'b0;
            fwd_hit_reg   <= 1'b0;
            res_cnt_reg   <= '0;
            clr_cnt_reg   <= '0;
            init_done_reg <= 1'b0;
            ob_wptr_reg   <= 1'b0;
            ob_rptr_reg   <= 1'b0;
            ob_cnt_reg    <= '0;
        end else begin
            rd_state_reg  <= rd_state_next;
            step_reg      <= step_next;
            rd_live_d_reg <= rd_live_d_next;
            rd_step_d_reg <= rd_step_d_next;
            w2_reg        <= w2_next;
            fwd_hit_reg   <= fwd_hit_next;
            res_cnt_reg   <= res_cnt_next;
            clr_cnt_reg   <= clr_cnt_next;
            init_done_reg <= init_done_next;
            ob_cnt_reg    <= ob_cnt_next;
            if (w2_reg) begin
                ob_wptr_reg <= ~ob_wptr_reg;
            end
            if (out_take) begin
                ob_rptr_reg <= ~ob_rptr_reg;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        rd_stream_reg <= rd_stream_next;
        rd_pos_reg    <= rd_pos_next;
        fwd_pos_reg   <= fwd_pos_next;
        wr_stream_reg <= wr_stream_next;
        wr_pos_reg    <= wr_pos_next;
        nw_reg        <= nw_next;
        if (rd_live_d_reg && (rd_step_d_reg != LAST_STEP)) begin
            w_reg[rd_step_d_reg[1:0]] <= ring_rdata;
        end
        if (w2_reg) begin
            ob_data_reg[ob_wptr_reg].random_word <= nw_reg;
            ob_data_reg[ob_wptr_reg].stream_out  <= STREAM_W'(wr_stream_reg);
        end
    end

endmodule

@@ rtl/core/well1024a_multi_stream_rng.sv @@
`timescale 1ns / 1ps
// Usage:
// WELL1024a generator with up to THREADS independent streams (at most 128 are reachable).
// Input channel s_*: one command beat per handshake. A draw command steps the addressed
// stream and returns one beat on m_*; a seed command writes one ring word of a stream,
// clears that stream's ring position and returns nothing. Commands for a stream at or
// above THREADS are dropped.
// Pipelining: draws are limited by the five reads of the single read port of the ring
// memory; the next draw's reads may start after the last read of the previous one and
// overlap its two write-backs. A seed is written when accepted but waits until earlier
// draws have finished their write-backs.
// Reset: after aresetn is released a clearing pass writes zero to every ring word and
// position, one ring word per cycle, 32 words per reachable stream (4096 by default);
// s_ready stays low until done.
// Every stream must be seeded before use, since an all-zero ring keeps drawing zero.
// Stall: a 2-beat command queue and a 2-beat result buffer decouple the sides; when
// m_ready is low, draws stop issuing once two results are outstanding.
module well1024a_multi_stream_rng
    import wellrng_pkg::*;
#(
    parameter int THREADS = THREADS_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  rng_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output rng_out_t m_data
);

    logic    init_done;
    logic    push_valid, push_ready;
    rng_in_t push_data;
    logic    q_valid, q_ready;
    rng_in_t q_data;

    wellrng_front #(.THREADS(THREADS)) u_front (
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .init_done  (init_done),
        .push_ready (push_ready),
        .push_valid (push_valid),
        .push_data  (push_data)
    );

    wellrng_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_data   (push_data),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_data)
    );

    wellrng_exec #(.THREADS(THREADS)) u_exec (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_data    (q_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .init_done (init_done)
    );

endmodule
